/* rtl/tdsp_pkg.sv */
// shared types and constants for the time and date line parser
// no dependencies; imported by every module of the block

package tdsp_pkg;

   localparam int unsigned CHAR_W        = 8;
   localparam int unsigned NUM_FIELDS    = 6;
   localparam int unsigned FIELD_W       = 8;
   localparam int unsigned INDEX_W       = 3;
   localparam int unsigned DIGIT_W       = 4;
   localparam int unsigned SUM_W         = 11;
   localparam int unsigned REQ_DATA_W    = 8;
   localparam int unsigned RSP_DATA_W    = 40;
   localparam int unsigned QUEUE_DEPTH_D = 2;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;

   // field limits
   localparam logic [FIELD_W-1:0] HOUR_MAX      = 8'd23;
   localparam logic [FIELD_W-1:0] MIN_SEC_MAX   = 8'd59;
   localparam logic [FIELD_W-1:0] DAY_MAX       = 8'd31;
   localparam logic [FIELD_W-1:0] SHORT_DAY_MAX = 8'd30;
   localparam logic [FIELD_W-1:0] MONTH_MAX     = 8'd12;
   localparam logic [FIELD_W-1:0] YEAR_MAX      = 8'd99;
   localparam logic [SUM_W-1:0]   SUM_MIN       = 11'd6;
   localparam logic [FIELD_W-1:0] ACCUM_SAT     = 8'd255;

   // months with fewer than 31 days
   localparam logic [FIELD_W-1:0] MONTH_FEB = 8'd2;
   localparam logic [FIELD_W-1:0] MONTH_APR = 8'd4;
   localparam logic [FIELD_W-1:0] MONTH_JUN = 8'd6;
   localparam logic [FIELD_W-1:0] MONTH_SEP = 8'd9;
   localparam logic [FIELD_W-1:0] MONTH_NOV = 8'd11;

   // field positions
   localparam int unsigned F_HOUR  = 0;
   localparam int unsigned F_MIN   = 1;
   localparam int unsigned F_SEC   = 2;
   localparam int unsigned F_DAY   = 3;
   localparam int unsigned F_MONTH = 4;
   localparam int unsigned F_YEAR  = 5;

   typedef enum logic [1:0] {
      TOK_DIGIT,
      TOK_SEP,
      TOK_END
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type       kind;
      logic [DIGIT_W-1:0] digit;
   } tok_type;

   typedef struct packed {
      logic [6:0] year_two_digit;
      logic [3:0] month_num;
      logic [4:0] day_of_month;
      logic [5:0] seconds;
      logic [5:0] minutes;
      logic [4:0] hours;
      logic       ok;
   } result_type;

endpackage

/* rtl/tdsp_front.sv */
// front end: classifies each input character into a token
// depends on tdsp_pkg

module tdsp_front
   import tdsp_pkg::*;
(
   input  logic [CHAR_W-1:0] char_in,
   output tok_type           tok
);

   logic [DIGIT_W-1:0] offset;

   assign offset = char_in[DIGIT_W-1:0] - CHAR_ZERO[DIGIT_W-1:0];

   always_comb begin
      tok.digit = offset;
      priority if (char_in >= CHAR_ZERO && char_in <= CHAR_NINE) begin
         tok.kind = TOK_DIGIT;
      end else if (char_in == CHAR_NEWLINE || char_in == CHAR_NUL) begin
         tok.kind = TOK_END;
      end else begin
         tok.kind = TOK_SEP;
      end
   end

endmodule

/* rtl/tdsp_queue.sv */
// short token queue between front end and back end
// depends on tdsp_pkg

module tdsp_queue
   import tdsp_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_D
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  tok_type push_tok,
   output logic    not_full,
   input  logic    pop,
   output logic    not_empty,
   output tok_type head_tok
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   tok_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign not_full  = (count_ff != CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_tok  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_tok;
      end
   end

endmodule

/* rtl/tdsp_back.sv */
// back end: digit accumulation, field stepping, line validation, result register
// depends on tdsp_pkg

module tdsp_back
   import tdsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       tok_valid,
   input  tok_type    tok,
   output logic       tok_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   logic [FIELD_W-1:0] accum_ff [NUM_FIELDS];
   logic [FIELD_W-1:0] accum_in [NUM_FIELDS];
   logic [INDEX_W-1:0] index_ff, index_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   logic               slot_free;
   logic               index_live;
   logic [FIELD_W-1:0] cur;
   logic [11:0]        next_val;
   logic [SUM_W-1:0]   sum;
   logic               short_month;
   logic               line_ok;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign tok_pop    = tok_valid && (tok.kind != TOK_END || slot_free);
   assign index_live = (index_ff < INDEX_W'(NUM_FIELDS));
   assign cur        = index_live ? accum_ff[index_ff] : '0;

   // accum*10 + digit, saturating at the top of the byte
   assign next_val = {1'b0, cur, 3'b000} + {3'b000, cur, 1'b0} + {8'h00, tok.digit};

   always_comb begin
      sum = '0;
      for (int k = 0; k < NUM_FIELDS; k++) begin
         sum = sum + SUM_W'(accum_ff[k]);
      end
   end

   assign short_month = (accum_ff[F_MONTH] == MONTH_FEB) || (accum_ff[F_MONTH] == MONTH_APR)
                     || (accum_ff[F_MONTH] == MONTH_JUN) || (accum_ff[F_MONTH] == MONTH_SEP)
                     || (accum_ff[F_MONTH] == MONTH_NOV);

   assign line_ok = (sum >= SUM_MIN)
                 && (accum_ff[F_HOUR]  <= HOUR_MAX)
                 && (accum_ff[F_MIN]   <= MIN_SEC_MAX)
                 && (accum_ff[F_SEC]   <= MIN_SEC_MAX)
                 && (accum_ff[F_DAY]   <= DAY_MAX)
                 && !((accum_ff[F_DAY] > SHORT_DAY_MAX) && short_month)
                 && (accum_ff[F_MONTH] <= MONTH_MAX)
                 && (accum_ff[F_YEAR]  <= YEAR_MAX);

   always_comb begin
      accum_in     = accum_ff;
      index_in     = index_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (tok_pop) begin
         unique case (tok.kind)
            TOK_DIGIT: begin
               if (index_live) begin
                  accum_in[index_ff] = (next_val > {4'h0, ACCUM_SAT}) ? ACCUM_SAT
                                                                      : next_val[FIELD_W-1:0];
               end
            end
            TOK_SEP: begin
               if (index_live) begin
                  index_in = index_ff + INDEX_W'(1);
               end
            end
            TOK_END: begin
               rsp_valid_in = 1'b1;
               if (line_ok) begin
                  rsp_in.ok             = 1'b1;
                  rsp_in.hours          = accum_ff[F_HOUR][4:0];
                  rsp_in.minutes        = accum_ff[F_MIN][5:0];
                  rsp_in.seconds        = accum_ff[F_SEC][5:0];
                  rsp_in.day_of_month   = accum_ff[F_DAY][4:0];
                  rsp_in.month_num      = accum_ff[F_MONTH][3:0];
                  rsp_in.year_two_digit = accum_ff[F_YEAR][6:0];
               end else begin
                  rsp_in = '0;
               end
               for (int k = 0; k < NUM_FIELDS; k++) begin
                  accum_in[k] = '0;
               end
               index_in = '0;
            end
            default: begin
               index_in = index_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_FIELDS; k++) begin
            accum_ff[k] <= '0;
         end
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         accum_ff     <= accum_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* rtl/time_date_string_parser_unit.sv */
// top level of the time and date line parser
// depends on tdsp_pkg, tdsp_front, tdsp_queue, tdsp_back
//
//   channel | dir | words                     | tdata fields, lowest bit up
//   req_    | in  | one ascii char per word   | char_in[7:0]
//   rsp_    | out | one word per ended line   | ok, hours, minutes, seconds,
//           |     |                           | day_of_month, month_num, year_two_digit
//
// one character per cycle sustained while the queue is not full; a result word
// is registered: its newline or nul passes through a queue slot, then the
// result register, before the word is presented on rsp_
// synchronous active-high reset clears the queue, accumulators, field index
// and the result valid flag
// a stalled rsp_ halts the queue only when a line-ending token reaches its head
// while a result word still waits; everything behind it waits too, and
// req_tready drops once the queue is full

module time_date_string_parser_unit
   import tdsp_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_D
)
(
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // char_in[7:0]
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // ok[0], hours[5:1], minutes[11:6],
                                              // seconds[17:12], day_of_month[22:18],
                                              // month_num[26:23], year_two_digit[33:27],
                                              // zero[39:34]
);

   tok_type    front_tok;
   tok_type    head_tok;
   logic       q_not_full;
   logic       q_not_empty;
   logic       q_pop;
   result_type rsp;

   // classify the incoming character
   tdsp_front u_front (
      .char_in (req_tdata[CHAR_W-1:0]),
      .tok     (front_tok)
   );

   // decouples classification from execution
   tdsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && q_not_full),
      .push_tok  (front_tok),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_tok  (head_tok)
   );

   // accumulate fields and validate finished lines
   tdsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (q_not_empty),
      .tok       (head_tok),
      .tok_pop   (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign req_tready = q_not_full;
   // packed struct has ok in the lowest bit; pad up to whole bytes
   assign rsp_tdata  = {(RSP_DATA_W - $bits(result_type))'(0), rsp};

endmodule
